// File: design/script_tokenizer_assert.svh
// Assertion macros used by the tokenizer top level.
`ifndef SCRIPT_TOKENIZER_ASSERT_SVH
`define SCRIPT_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define STOK_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define STOK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define STOK_ASSERT(label, expr)
`define STOK_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// File: design/stok_pkg.sv
// Types, codes and decode functions of the script tokenizer.
package stok_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RES = 3;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_SLASH   = 3'd1;
  localparam logic [2:0] MODE_LITERAL = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  localparam logic [2:0] KIND_CHAR    = 3'd0;
  localparam logic [2:0] KIND_LITEND  = 3'd1;
  localparam logic [2:0] KIND_STREND  = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_LSTART  = 3'd4;
  localparam logic [2:0] KIND_LEND    = 3'd5;
  localparam logic [2:0] KIND_EOF     = 3'd6;
  localparam logic [2:0] KIND_EOL     = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
  } stok_res_t;

  typedef struct packed {
    logic [1:0]           count;
    stok_res_t [MAX_RES-1:0] res;
    logic [2:0]           mode_next;
  } stok_dec_t;

  typedef struct packed {
    logic       last;
    logic [7:0] ch;
    logic [2:0] kind;
  } stok_word_t;

  function automatic logic is_lit_char(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_SLASH || c == CH_DOT ||
           c == CH_UNDER;
  endfunction

  function automatic stok_dec_t add_res(stok_dec_t d, logic [2:0] kind, logic [7:0] ch);
    stok_dec_t r;
    r = d;
    if (r.count != 2'd3) begin
      r.res[r.count].kind = kind;
      r.res[r.count].ch = (kind == KIND_CHAR) ? ch : 8'h00;
      r.count = r.count + 2'd1;
    end
    return r;
  endfunction

  function automatic stok_dec_t idle_byte(stok_dec_t d, logic nl, logic [7:0] c);
    stok_dec_t r;
    r = d;
    r.mode_next = MODE_IDLE;
    case (c)
      CH_NUL: r = add_res(r, KIND_EOF, 8'h00);
      CH_SPACE, CH_TAB: ;
      CH_NL: begin
        if (nl) r = add_res(r, KIND_EOL, 8'h00);
      end
      CH_LBRACE: r = add_res(r, KIND_LSTART, 8'h00);
      CH_RBRACE: r = add_res(r, KIND_LEND, 8'h00);
      CH_QUOTE: r.mode_next = MODE_STRING;
      CH_SLASH: r.mode_next = MODE_SLASH;
      default: begin
        r = add_res(r, KIND_CHAR, c);
        r.mode_next = MODE_LITERAL;
      end
    endcase
    return r;
  endfunction

  function automatic stok_dec_t literal_byte(stok_dec_t d, logic nl, logic [7:0] c);
    stok_dec_t r;
    r = d;
    if (c == CH_NUL) begin
      r = add_res(r, KIND_EOF, 8'h00);
      r.mode_next = MODE_IDLE;
    end else if (is_lit_char(c)) begin
      r = add_res(r, KIND_CHAR, c);
      r.mode_next = MODE_LITERAL;
    end else begin
      r = add_res(r, KIND_LITEND, 8'h00);
      r = idle_byte(r, nl, c);
    end
    return r;
  endfunction

endpackage

// File: design/script_tokenizer.sv
// Top level of the script tokenizer: input register, decoder and result queue.
// A text byte is accepted in every cycle while the result queue has room for
// three words; it is held in the input register and decoded there, and its
// zero to three result words are written into a four-word queue at once.
// Words leave the queue one per cycle while m_tready is high, so the
// sustained rate is one byte per cycle for text that yields at most one word
// per byte, and lower for bytes that yield more words. tlast marks the final
// word caused by one byte.
`include "script_tokenizer_assert.svh"

module script_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] input_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] token_kind, [10:3] token_char, [15:11] zero
  output logic        m_tlast    // last
);

  localparam int PTR_W = $clog2(stok_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic                newline_mode;
  logic [2:0]          mode;
  logic                byte_valid;
  logic [7:0]          byte_r;
  logic                move;
  logic                pop;
  stok_pkg::stok_dec_t dec;

  stok_pkg::stok_word_t queue [stok_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic [1:0]           push_n;

  stok_decode u_decode (
    .mode    (mode),
    .nl_mode (newline_mode),
    .c       (byte_r),
    .dec     (dec)
  );

  assign move     = byte_valid && (count <= CNT_W'(stok_pkg::QUEUE_DEPTH - stok_pkg::MAX_RES));
  assign push_n   = move ? dec.count : 2'd0;
  assign s_tready = !byte_valid || move;
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {5'd0, queue[rd_ptr].ch, queue[rd_ptr].kind};
  assign m_tlast  = queue[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      newline_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      newline_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      mode       <= stok_pkg::MODE_IDLE;
    end else begin
      if (s_tready) begin
        byte_valid <= s_tvalid;
      end
      if (move) begin
        mode <= dec.mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_r <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int i = 0; i < stok_pkg::MAX_RES; i++) begin
        if (2'(i) < dec.count) begin
          queue[wr_ptr + PTR_W'(i)] <= '{last: (2'(i) == dec.count - 2'd1),
                                         ch:   dec.res[i].ch,
                                         kind: dec.res[i].kind};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  `STOK_ASSERT(a_count_bound, count <= CNT_W'(stok_pkg::QUEUE_DEPTH))
  `STOK_ASSERT(a_mode_legal, mode <= stok_pkg::MODE_COMMENT)
  `STOK_ASSERT_IMPL(a_count_track, !$past(rst),
    count == $past(count) + CNT_W'($past(push_n)) - CNT_W'($past(pop)))
  `STOK_ASSERT_IMPL(a_room_on_move, move,
    count + CNT_W'(dec.count) <= CNT_W'(stok_pkg::QUEUE_DEPTH))

endmodule

// File: design/stok_decode.sv
// Decoder that turns one byte and the lexer mode into up to three result words.
module stok_decode (
  input  logic [2:0]          mode,
  input  logic                nl_mode,
  input  logic [7:0]          c,
  output stok_pkg::stok_dec_t dec
);

  stok_pkg::stok_dec_t d;

  always_comb begin
    d = '0;
    d.mode_next = mode;
    case (mode)
      stok_pkg::MODE_SLASH: begin
        if (c == stok_pkg::CH_NUL) begin
          d = stok_pkg::add_res(d, stok_pkg::KIND_EOF, 8'h00);
          d.mode_next = stok_pkg::MODE_IDLE;
        end else if (c == stok_pkg::CH_SLASH) begin
          d.mode_next = stok_pkg::MODE_COMMENT;
        end else begin
          d = stok_pkg::add_res(d, stok_pkg::KIND_CHAR, stok_pkg::CH_SLASH);
          d = stok_pkg::literal_byte(d, nl_mode, c);
        end
      end
      stok_pkg::MODE_LITERAL: d = stok_pkg::literal_byte(d, nl_mode, c);
      stok_pkg::MODE_STRING: begin
        if (c == stok_pkg::CH_NUL) begin
          d = stok_pkg::add_res(d, stok_pkg::KIND_EOF, 8'h00);
          d.mode_next = stok_pkg::MODE_IDLE;
        end else if (c == stok_pkg::CH_QUOTE) begin
          d = stok_pkg::add_res(d, stok_pkg::KIND_STREND, 8'h00);
          d.mode_next = stok_pkg::MODE_IDLE;
        end else begin
          d = stok_pkg::add_res(d, stok_pkg::KIND_CHAR, c);
        end
      end
      stok_pkg::MODE_COMMENT: begin
        if (c == stok_pkg::CH_NUL) begin
          d = stok_pkg::add_res(d, stok_pkg::KIND_EOF, 8'h00);
          d.mode_next = stok_pkg::MODE_IDLE;
        end else if (c == stok_pkg::CH_NL) begin
          d = stok_pkg::add_res(d, stok_pkg::KIND_COMMENT, 8'h00);
          d.mode_next = stok_pkg::MODE_IDLE;
        end
      end
      default: d = stok_pkg::idle_byte(d, nl_mode, c);
    endcase
  end

  assign dec = d;

endmodule
